// ----- rtl/tpp_pkg.sv -----
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants for the thermal and power protection unit.
// ----------------------------------------------------------------------------
package tpp_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_CTRL       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FAN_START  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FAN_FULL   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_LIMIT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PWR_LIMIT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BEEP_DUR   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BEEP_CNT   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL   = 3'd7;

    // control flag bit positions
    localparam int FLAG_FAN   = 0;
    localparam int FLAG_SHDN  = 1;
    localparam int FLAG_ALERT = 2;
    localparam int FLAG_BUZZ  = 3;
    localparam int FLAG_TACH  = 4;

    // register reset values
    localparam logic [4:0]  RST_CTRL       = 5'd0;
    localparam logic [15:0] RST_FAN_START  = 16'd3840;
    localparam logic [15:0] RST_FAN_FULL   = 16'd6400;
    localparam logic [14:0] RST_TEMP_LIMIT = 15'd10880;
    localparam logic [23:0] RST_PWR_LIMIT  = 24'd25000;
    localparam logic [15:0] RST_BEEP_DUR   = 16'd500;
    localparam logic [7:0]  RST_BEEP_CNT   = 8'd3;
    localparam logic [15:0] RST_INTERVAL   = 16'd1000;

    // shutdown reason codes
    localparam logic [1:0] RSN_NONE  = 2'd0;
    localparam logic [1:0] RSN_ALERT = 2'd1;
    localparam logic [1:0] RSN_LIMIT = 2'd2;

    // arithmetic constants
    localparam logic [7:0]  DUTY_FULL  = 8'd255;
    localparam logic [6:0]  PCT_FULL   = 7'd100;
    localparam logic [15:0] RPM_SCALE  = 16'd60000;
    localparam logic [15:0] TICK_MAX   = 16'hFFFF;
    localparam logic [7:0]  BEEPS_MAX  = 8'hFF;

    // shared divider
    localparam int DIV_W = 32;
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_DUTY_WAIT,
        ST_RPM_MUL,
        ST_RPM_DIV,
        ST_RPM_WAIT,
        ST_FINISH,
        ST_OUT
    } tpp_state_t;

endpackage

// ----- rtl/thermal_power_protection_unit.sv -----
// ----------------------------------------------------------------------------
// thermal_power_protection_unit
// Fan control, tach RPM, shutdown latch and beep sequencer, one transfer per
// millisecond tick.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                         | content
//  ---------+-----------+---------------------------------+--------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tuser | one tick
//  m_       | out       | m_tvalid m_tready m_tdata       | one status word/tick
//  cfg_     | in        | cfg_wr_en cfg_addr cfg_wdata    | register writes
//
// A tick without a sample goes from ST_PRE straight to ST_OUT; a sample tick
// also passes the fan, RPM and finish states. The shared divider serves the
// fan duty (only when the temperature lies strictly inside the fan ramp) and
// the RPM (only when a tach is present). s_tready is high only in idle. The
// result sits in an output register, so the next tick is taken while it
// waits on m_tready. aresetn is synchronous; it clears all status and loads
// defaults.
// ----------------------------------------------------------------------------
module thermal_power_protection_unit #(
    parameter int PULSES_PER_REV = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tick input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] temperature, [39:16] power_mw, [40] alert_low,
    // [56:41] tach_pulses, [57] clear_request
    input  logic [63:0]                    s_tdata,
    // [0] sample_valid
    input  logic                           s_tuser,
    // status output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] fan_duty, [14:8] fan_percent, [30:15] fan_rpm,
    // [31] shutdown_latched, [33:32] shutdown_reason, [34] force_off,
    // [35] buzzer_on, [51:36] captured_temperature, [75:52] captured_power_mw
    output logic [79:0]                    m_tdata,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [tpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tpp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tpp_pkg::*;

    // ---------------- configuration registers ----------------
    logic [4:0]         flags_reg;
    logic signed [15:0] fan_start_reg;
    logic signed [15:0] fan_full_reg;
    logic [14:0]        temp_limit_reg;
    logic [23:0]        pwr_limit_reg;
    logic [15:0]        beep_dur_reg;
    logic [7:0]         beep_cnt_reg;
    logic [15:0]        interval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg      <= RST_CTRL;
            fan_start_reg  <= RST_FAN_START;
            fan_full_reg   <= RST_FAN_FULL;
            temp_limit_reg <= RST_TEMP_LIMIT;
            pwr_limit_reg  <= RST_PWR_LIMIT;
            beep_dur_reg   <= RST_BEEP_DUR;
            beep_cnt_reg   <= RST_BEEP_CNT;
            interval_reg   <= RST_INTERVAL;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CTRL:       flags_reg      <= cfg_wdata[4:0];
                REG_FAN_START:  fan_start_reg  <= cfg_wdata[15:0];
                REG_FAN_FULL:   fan_full_reg   <= cfg_wdata[15:0];
                REG_TEMP_LIMIT: temp_limit_reg <= cfg_wdata[14:0];
                REG_PWR_LIMIT:  pwr_limit_reg  <= cfg_wdata[23:0];
                REG_BEEP_DUR:   beep_dur_reg   <= cfg_wdata[15:0];
                REG_BEEP_CNT:   beep_cnt_reg   <= cfg_wdata[7:0];
                REG_INTERVAL:   interval_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic fan_en, shdn_en, alert_en, buzz_en, tach_en;
    assign fan_en   = flags_reg[FLAG_FAN];
    assign shdn_en  = flags_reg[FLAG_SHDN];
    assign alert_en = flags_reg[FLAG_ALERT];
    assign buzz_en  = flags_reg[FLAG_BUZZ];
    assign tach_en  = flags_reg[FLAG_TACH];

    // ---------------- state ----------------
    tpp_state_t state_reg, state_next;

    // captured tick
    logic               in_valid_reg, in_valid_next;
    logic signed [15:0] in_temp_reg, in_temp_next;
    logic [23:0]        in_power_reg, in_power_next;
    logic               in_alert_reg, in_alert_next;
    logic [15:0]        in_tach_reg, in_tach_next;
    logic               in_clear_reg, in_clear_next;

    // status
    logic [7:0]         duty_reg, duty_next;
    logic [6:0]         pct_reg, pct_next;
    logic [15:0]        rpm_reg, rpm_next;
    logic               latched_reg, latched_next;
    logic [1:0]         reason_reg, reason_next;
    logic [15:0]        held_temp_reg, held_temp_next;
    logic [23:0]        held_power_reg, held_power_next;
    logic               force_reg, force_next;

    // beep sequencer
    logic               bp_active_reg, bp_active_next;
    logic               bp_pause_reg, bp_pause_next;
    logic [7:0]         beeps_reg, beeps_next;
    logic [15:0]        ticks_reg, ticks_next;

    // RPM operands
    logic [DIV_W-1:0]   rpm_num_reg, rpm_num_next;
    logic [DIV_W-1:0]   rpm_den_reg, rpm_den_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [79:0]        m_data_reg, m_data_next;

    // divider
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quotient;

    tpp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ---------------- combinational helpers ----------------
    logic signed [16:0] temp_diff;    // T - start
    logic signed [16:0] ramp_span;    // full - start
    logic [23:0]        duty_num;
    logic               limits_on;
    logic [1:0]         why;
    logic               latched_clr;
    logic [15:0]        tick_inc;
    logic [7:0]         beep_inc;
    logic [14:0]        pct_x;
    logic [15:0]        pct_q;
    logic [15:0]        iv_eff;

    assign temp_diff = {in_temp_reg[15], in_temp_reg} - {fan_start_reg[15], fan_start_reg};
    assign ramp_span = {fan_full_reg[15], fan_full_reg} - {fan_start_reg[15], fan_start_reg};
    assign duty_num  = 24'(temp_diff[15:0]) * 24'(DUTY_FULL);

    assign limits_on = (temp_limit_reg != '0) || (pwr_limit_reg != '0);

    always_comb begin
        why = RSN_NONE;
        if (shdn_en) begin
            if (alert_en && limits_on && in_alert_reg)
                why = RSN_ALERT;
            else if (temp_limit_reg != '0 &&
                     in_temp_reg >= $signed({1'b0, temp_limit_reg}))
                why = RSN_LIMIT;
            else if (pwr_limit_reg != '0 && in_power_reg >= pwr_limit_reg)
                why = RSN_LIMIT;
        end
    end

    assign latched_clr = in_clear_reg ? 1'b0 : latched_reg;
    assign tick_inc    = (ticks_reg != TICK_MAX) ? ticks_reg + 16'd1 : ticks_reg;
    assign beep_inc    = (beeps_reg != BEEPS_MAX) ? beeps_reg + 8'd1 : beeps_reg;

    // floor(x / 255) for the 15-bit x = duty * 100
    assign pct_x = 15'(duty_reg) * 15'(PCT_FULL);
    assign pct_q = 16'(pct_x) + 16'd1 + 16'(pct_x >> 8);

    assign iv_eff = (interval_reg != '0) ? interval_reg : 16'd1;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        in_valid_next   = in_valid_reg;
        in_temp_next    = in_temp_reg;
        in_power_next   = in_power_reg;
        in_alert_next   = in_alert_reg;
        in_tach_next    = in_tach_reg;
        in_clear_next   = in_clear_reg;
        duty_next       = duty_reg;
        pct_next        = pct_reg;
        rpm_next        = rpm_reg;
        latched_next    = latched_reg;
        reason_next     = reason_reg;
        held_temp_next  = held_temp_reg;
        held_power_next = held_power_reg;
        force_next      = force_reg;
        bp_active_next  = bp_active_reg;
        bp_pause_next   = bp_pause_reg;
        beeps_next      = beeps_reg;
        ticks_next      = ticks_reg;
        rpm_num_next    = rpm_num_reg;
        rpm_den_next    = rpm_den_reg;
        m_data_next     = m_data_reg;
        div_start       = 1'b0;
        div_dividend    = DIV_W'(duty_num);
        div_divisor     = DIV_W'(ramp_span[15:0]);

        // result leaves when taken
        m_valid_next = m_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    in_valid_next = s_tuser;
                    in_temp_next  = s_tdata[15:0];
                    in_power_next = s_tdata[39:16];
                    in_alert_next = s_tdata[40];
                    in_tach_next  = s_tdata[56:41];
                    in_clear_next = s_tdata[57];
                    state_next    = ST_PRE;
                end
            end

            ST_PRE: begin
                // clear request empties the latch, sequencer keeps going
                if (in_clear_reg) begin
                    latched_next    = 1'b0;
                    reason_next     = RSN_NONE;
                    held_temp_next  = '0;
                    held_power_next = '0;
                end

                // beep/pause step
                if (bp_active_reg && buzz_en) begin
                    ticks_next = tick_inc;
                    if (tick_inc >= beep_dur_reg) begin
                        ticks_next = '0;
                        if (!bp_pause_reg) begin
                            beeps_next = beep_inc;
                            if (beep_inc >= beep_cnt_reg) begin
                                bp_active_next = 1'b0;
                                bp_pause_next  = 1'b0;
                            end else begin
                                bp_pause_next = 1'b1;
                            end
                        end else begin
                            bp_pause_next = 1'b0;
                        end
                    end
                end

                force_next = 1'b0;
                if (!in_valid_reg) begin
                    state_next = ST_OUT;
                end else begin
                    // shutdown check; first trigger captures and, with the buzzer on, starts beeps
                    force_next = (why != RSN_NONE);
                    if (why != RSN_NONE && !latched_clr) begin
                        latched_next    = 1'b1;
                        reason_next     = why;
                        held_temp_next  = in_temp_reg;
                        held_power_next = in_power_reg;
                        if (buzz_en && beep_cnt_reg != '0) begin
                            bp_active_next = 1'b1;
                            bp_pause_next  = 1'b0;
                            beeps_next     = '0;
                            ticks_next     = '0;
                        end
                    end

                    // fan ramp
                    state_next = ST_RPM_MUL;
                    if (!fan_en) begin
                        duty_next = '0;
                    end else if (in_temp_reg <= fan_start_reg) begin
                        duty_next = '0;
                    end else if (in_temp_reg >= fan_full_reg) begin
                        duty_next = DUTY_FULL;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DUTY_WAIT;
                    end
                end
            end

            ST_DUTY_WAIT: begin
                // quotient stays below 255 inside the ramp
                if (div_done) begin
                    duty_next  = div_quotient[7:0];
                    state_next = ST_RPM_MUL;
                end
            end

            ST_RPM_MUL: begin
                if (tach_en) begin
                    rpm_num_next = DIV_W'(in_tach_reg) * DIV_W'(RPM_SCALE);
                    rpm_den_next = DIV_W'(iv_eff) * DIV_W'(PULSES_PER_REV);
                    state_next   = ST_RPM_DIV;
                end else begin
                    state_next = ST_FINISH;
                end
            end

            ST_RPM_DIV: begin
                div_start    = 1'b1;
                div_dividend = rpm_num_reg;
                div_divisor  = rpm_den_reg;
                state_next   = ST_RPM_WAIT;
            end

            ST_RPM_WAIT: begin
                if (div_done) begin
                    rpm_next   = (div_quotient[DIV_W-1:16] != '0) ? TICK_MAX
                                                                  : div_quotient[15:0];
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                // critical condition forces full fan
                if (force_reg && fan_en) begin
                    duty_next = DUTY_FULL;
                    pct_next  = PCT_FULL;
                end else begin
                    pct_next = pct_q[14:8];
                end
                state_next = ST_OUT;
            end

            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, held_power_reg, held_temp_reg,
                                    bp_active_reg && !bp_pause_reg, force_reg,
                                    reason_reg, latched_reg, rpm_reg, pct_reg,
                                    duty_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            duty_reg       <= '0;
            pct_reg        <= '0;
            rpm_reg        <= '0;
            latched_reg    <= 1'b0;
            reason_reg     <= RSN_NONE;
            held_temp_reg  <= '0;
            held_power_reg <= '0;
            force_reg      <= 1'b0;
            bp_active_reg  <= 1'b0;
            bp_pause_reg   <= 1'b0;
            beeps_reg      <= '0;
            ticks_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            duty_reg       <= duty_next;
            pct_reg        <= pct_next;
            rpm_reg        <= rpm_next;
            latched_reg    <= latched_next;
            reason_reg     <= reason_next;
            held_temp_reg  <= held_temp_next;
            held_power_reg <= held_power_next;
            force_reg      <= force_next;
            bp_active_reg  <= bp_active_next;
            bp_pause_reg   <= bp_pause_next;
            beeps_reg      <= beeps_next;
            ticks_reg      <= ticks_next;
            m_valid_reg    <= m_valid_next;
        end
        in_valid_reg <= in_valid_next;
        in_temp_reg  <= in_temp_next;
        in_power_reg <= in_power_next;
        in_alert_reg <= in_alert_next;
        in_tach_reg  <= in_tach_next;
        in_clear_reg <= in_clear_next;
        rpm_num_reg  <= rpm_num_next;
        rpm_den_reg  <= rpm_den_next;
        m_data_reg   <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/tpp_div.sv -----
// ----------------------------------------------------------------------------
// tpp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpp_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [tpp_pkg::DIV_W-1:0] dividend,
    input  logic [tpp_pkg::DIV_W-1:0] divisor,
    output logic                     done,
    output logic [tpp_pkg::DIV_W-1:0] quotient
);
    import tpp_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // borrow clear: divisor fits, keep the difference
            if (!trial[DIV_W]) begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- tb/sv/thermal_power_protection_unit_tb.sv -----
// ----------------------------------------------------------------------------
// thermal_power_protection_unit_tb
// Self-checking bench for the thermal and power protection unit. Ticks go in
// through the s_ stream and status words come out on the m_ stream. A model
// kept inside the bench predicts every status word, and each one is checked
// field by field against it. The bench runs a directed set of ticks, then
// random ticks under several register settings and under varied back-pressure.
// ----------------------------------------------------------------------------
module thermal_power_protection_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpp_pkg::*;

    localparam int TACH_PPR      = 2;      // pulses per fan revolution
    localparam int HALF_PHASE    = 83;     // random ticks per half phase
    localparam int RAND_PHASES   = 8;
    localparam int SETTLE_CYCLES = 8;      // quiet time before register writes
    localparam int END_WAIT      = 100;    // above the worst tick latency
    localparam int QUIET_LIMIT   = 20000;  // watchdog: cycles with no transfer

    // one tick as the bench sees it
    typedef struct {
        bit                 sample;
        logic signed [15:0] temp;
        logic [23:0]        power;
        bit                 alert;
        logic [15:0]        pulses;
        bit                 clear;
    } tick_t;

    // one status word
    typedef struct {
        logic [7:0]         duty;
        logic [6:0]         pct;
        logic [15:0]        rpm;
        logic               latched;
        logic [1:0]         reason;
        logic               forced;
        logic               buzzer;
        logic signed [15:0] cap_temp;
        logic [23:0]        cap_power;
    } status_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [79:0]           m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    thermal_power_protection_unit #(
        .PULSES_PER_REV(TACH_PPR)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Bench copy of the registers
    // ------------------------------------------------------------------
    logic [4:0]         flags_cfg;
    logic signed [15:0] ramp_lo;
    logic signed [15:0] ramp_hi;
    logic [14:0]        temp_trip;
    logic [23:0]        power_trip;
    logic [15:0]        beep_len;
    logic [7:0]         beep_total;
    logic [15:0]        tach_window;

    // Bench copy of the block's state
    logic [7:0]         duty_q;
    logic [6:0]         pct_q;
    logic [15:0]        rpm_q;
    logic               latch_q;
    logic [1:0]         reason_q;
    logic signed [15:0] cap_temp_q;
    logic [23:0]        cap_power_q;
    logic               beep_active_q;
    logic               beep_pause_q;
    logic [7:0]         beep_num_q;
    logic [15:0]        beep_ticks_q;

    tick_t   tick_pending[$];   // ticks still to be sent
    status_t status_due[$];     // predicted status words, oldest first
    tick_t   tick_on_bus;       // tick currently presented on s_

    int gap_pct   = 0;          // sender idle chance, percent
    int stall_pct = 0;          // receiver stall chance, percent
    int fails     = 0;
    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Status prediction for one tick. Order inside a tick: clear, then the
    // beep sequencer, then (on sample ticks) fan, tach and shutdown check.
    // ------------------------------------------------------------------
    function automatic status_t predict_status(tick_t t);
        status_t    r;
        logic [1:0] why;
        bit         forced;
        int         duty_v;
        longint     win;
        longint     rpm_v;
        why    = RSN_NONE;
        forced = 0;

        if (t.clear) begin
            latch_q     = 1'b0;
            reason_q    = RSN_NONE;
            cap_temp_q  = '0;
            cap_power_q = '0;
        end

        // sequencer freezes when the buzzer enable is off
        if (beep_active_q && flags_cfg[FLAG_BUZZ]) begin
            if (beep_ticks_q != TICK_MAX)
                beep_ticks_q++;
            if (beep_ticks_q >= beep_len) begin
                beep_ticks_q = '0;
                if (!beep_pause_q) begin
                    if (beep_num_q != BEEPS_MAX)
                        beep_num_q++;
                    if (beep_num_q >= beep_total) begin
                        beep_active_q = 1'b0;
                        beep_pause_q  = 1'b0;
                    end else begin
                        beep_pause_q = 1'b1;
                    end
                end else begin
                    beep_pause_q = 1'b0;
                end
            end
        end

        if (t.sample) begin
            if (!flags_cfg[FLAG_FAN]) begin
                duty_q = '0;
                pct_q  = '0;
            end else begin
                // a reversed or empty ramp falls out of the first two tests
                if (t.temp <= ramp_lo)
                    duty_v = 0;
                else if (t.temp >= ramp_hi)
                    duty_v = 255;
                else
                    duty_v = ((int'(t.temp) - int'(ramp_lo)) * 255) /
                             (int'(ramp_hi) - int'(ramp_lo));
                duty_q = duty_v[7:0];
                pct_q  = 7'((duty_v * 100) / 255);
            end

            // no tach: RPM holds its last value
            if (flags_cfg[FLAG_TACH]) begin
                win   = (tach_window == 0) ? 1 : longint'(tach_window);
                rpm_v = (longint'(t.pulses) * 60000) / (win * TACH_PPR);
                rpm_q = (rpm_v > 65535) ? 16'hFFFF : rpm_v[15:0];
            end

            if (flags_cfg[FLAG_SHDN]) begin
                // alert pin only counts with at least one limit armed
                if (flags_cfg[FLAG_ALERT] && (temp_trip != 0 || power_trip != 0) && t.alert)
                    why = RSN_ALERT;
                else if (temp_trip != 0 && int'(t.temp) >= int'(temp_trip))
                    why = RSN_LIMIT;
                else if (power_trip != 0 && t.power >= power_trip)
                    why = RSN_LIMIT;

                if (why != RSN_NONE) begin
                    forced = 1;
                    if (!latch_q) begin
                        latch_q     = 1'b1;
                        reason_q    = why;
                        cap_temp_q  = t.temp;
                        cap_power_q = t.power;
                        if (flags_cfg[FLAG_BUZZ] && beep_total != 0) begin
                            beep_active_q = 1'b1;
                            beep_pause_q  = 1'b0;
                            beep_num_q    = '0;
                            beep_ticks_q  = '0;
                        end
                    end
                    if (flags_cfg[FLAG_FAN]) begin
                        duty_q = DUTY_FULL;
                        pct_q  = PCT_FULL;
                    end
                end
            end
        end

        r.duty      = duty_q;
        r.pct       = pct_q;
        r.rpm       = rpm_q;
        r.latched   = latch_q;
        r.reason    = reason_q;
        r.forced    = forced;
        r.buzzer    = beep_active_q && !beep_pause_q;
        r.cap_temp  = cap_temp_q;
        r.cap_power = cap_power_q;
        return r;
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            fails++;
        end
    endfunction

    function automatic tick_t make_tick(bit sample, int temp, int power, bit alert,
                                        int pulses, bit clear);
        tick_t t;
        t.sample = sample;
        t.temp   = 16'(temp);
        t.power  = 24'(power);
        t.alert  = alert;
        t.pulses = 16'(pulses);
        t.clear  = clear;
        return t;
    endfunction

    // Random tick aimed at the current settings: around the fan ramp, around
    // the temperature and power trip points, at the extremes, or anywhere.
    function automatic tick_t random_tick();
        tick_t t;
        int    lo;
        int    hi;
        int    pick;
        int    v;
        t.sample = ($urandom_range(99) < 70);
        t.clear  = ($urandom_range(99) < 8);
        t.alert  = ($urandom_range(99) < 10);

        lo = (ramp_lo < ramp_hi) ? int'(ramp_lo) : int'(ramp_hi);
        hi = (ramp_lo < ramp_hi) ? int'(ramp_hi) : int'(ramp_lo);
        pick = $urandom_range(99);
        if (pick < 40)
            v = lo - 40 + int'($urandom_range(hi - lo + 80));
        else if (pick < 60)
            v = int'(temp_trip) - 8 + int'($urandom_range(16));
        else if (pick < 70)
            v = $urandom_range(1) ? 32767 : -32768;
        else
            v = int'($urandom_range(65535)) - 32768;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        t.temp = 16'(v);

        pick = $urandom_range(99);
        if (pick < 40) begin
            v = int'(power_trip) - 8 + int'($urandom_range(16));
            if (v < 0)
                v = 0;
            if (v > 24'hFFFFFF)
                v = 24'hFFFFFF;
        end else if (pick < 55) begin
            v = int'($urandom_range(24'hFFFFFF));
        end else if (pick < 65) begin
            v = $urandom_range(1) ? 24'hFFFFFF : 0;
        end else begin
            v = int'($urandom_range(40000));
        end
        t.power = 24'(v);

        pick = $urandom_range(99);
        if (pick < 30)
            t.pulses = 16'($urandom_range(65535));
        else if (pick < 40)
            t.pulses = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else
            t.pulses = 16'($urandom_range(300));
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Register writes; the bench copy follows each write
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CTRL:       flags_cfg   = val[4:0];
            REG_FAN_START:  ramp_lo     = val[15:0];
            REG_FAN_FULL:   ramp_hi     = val[15:0];
            REG_TEMP_LIMIT: temp_trip   = val[14:0];
            REG_PWR_LIMIT:  power_trip  = val[23:0];
            REG_BEEP_DUR:   beep_len    = val[15:0];
            REG_BEEP_CNT:   beep_total  = val[7:0];
            REG_INTERVAL:   tach_window = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [4:0] flags, int start, int full, int tlim,
                                  int plim, int dur, int cnt, int win);
        write_reg(REG_CTRL,       CFG_DATA_W'(flags));
        write_reg(REG_FAN_START,  CFG_DATA_W'(start & 16'hFFFF));
        write_reg(REG_FAN_FULL,   CFG_DATA_W'(full & 16'hFFFF));
        write_reg(REG_TEMP_LIMIT, CFG_DATA_W'(tlim));
        write_reg(REG_PWR_LIMIT,  CFG_DATA_W'(plim));
        write_reg(REG_BEEP_DUR,   CFG_DATA_W'(dur));
        write_reg(REG_BEEP_CNT,   CFG_DATA_W'(cnt));
        write_reg(REG_INTERVAL,   CFG_DATA_W'(win));
    endtask

    task automatic apply_random_settings();
        logic [4:0] flags;
        int         lo;
        int         hi;
        int         tlim;
        int         plim;
        int         win;
        // mostly shutdown and buzzer on so the latch and sequencer get work
        flags = 5'($urandom_range(31)) | (($urandom_range(3) != 0) ? 5'b01010 : 5'b00000);
        lo    = int'($urandom_range(12800)) - 2560;
        hi    = lo + int'($urandom_range(6000)) - 500;
        if (hi > 32767)
            hi = 32767;
        tlim  = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(14000, 6000));
        plim  = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(40000, 15000));
        win   = $urandom_range(1) ? int'($urandom_range(20, 1)) :
                                    int'($urandom_range(65535, 1));
        apply_settings(flags, lo, hi, tlim, plim, $urandom_range(6), $urandom_range(5), win);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 67; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 67; end
            default: begin gap_pct = 21; stall_pct = 21; end
        endcase
    endtask

    // hold until every tick is sent and every status word is back
    task automatic drain();
        while (tick_pending.size() != 0 || s_tvalid || status_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Tick driver: presents queued ticks, predicts each accepted transfer.
    // s_tvalid stays high across back-to-back ticks (one NBA per edge).
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        tick_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                status_due.push_back(predict_status(tick_on_bus));
            if (!s_tvalid || s_tready) begin
                if (tick_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    nxt = tick_pending.pop_front();
                    tick_on_bus <= nxt;
                    s_tvalid    <= 1'b1;
                    s_tuser     <= nxt.sample;
                    s_tdata     <= {6'd0, nxt.clear, nxt.pulses, nxt.alert,
                                    nxt.power, nxt.temp};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Status monitor: random back-pressure, compares each transfer with
    // the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        status_t got;
        status_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.duty      = m_tdata[7:0];
                got.pct       = m_tdata[14:8];
                got.rpm       = m_tdata[30:15];
                got.latched   = m_tdata[31];
                got.reason    = m_tdata[33:32];
                got.forced    = m_tdata[34];
                got.buzzer    = m_tdata[35];
                got.cap_temp  = m_tdata[51:36];
                got.cap_power = m_tdata[75:52];
                if (status_due.size() == 0) begin
                    $error("status transfer with no tick outstanding");
                    fails++;
                end else begin
                    want = status_due.pop_front();
                    check_field("fan_duty",             want.duty,      got.duty);
                    check_field("fan_percent",          want.pct,       got.pct);
                    check_field("fan_rpm",              want.rpm,       got.rpm);
                    check_field("shutdown_latched",     want.latched,   got.latched);
                    check_field("shutdown_reason",      want.reason,    got.reason);
                    check_field("force_off",            want.forced,    got.forced);
                    check_field("buzzer_on",            want.buzzer,    got.buzzer);
                    check_field("captured_temperature", want.cap_temp,  got.cap_temp);
                    check_field("captured_power_mw",    want.cap_power, got.cap_power);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer on either side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;

        // register defaults and cleared state, as after reset
        flags_cfg     = RST_CTRL;
        ramp_lo       = RST_FAN_START;
        ramp_hi       = RST_FAN_FULL;
        temp_trip     = RST_TEMP_LIMIT;
        power_trip    = RST_PWR_LIMIT;
        beep_len      = RST_BEEP_DUR;
        beep_total    = RST_BEEP_CNT;
        tach_window   = RST_INTERVAL;
        duty_q        = '0;
        pct_q         = '0;
        rpm_q         = '0;
        latch_q       = 1'b0;
        reason_q      = RSN_NONE;
        cap_temp_q    = '0;
        cap_power_q   = '0;
        beep_active_q = 1'b0;
        beep_pause_q  = 1'b0;
        beep_num_q    = '0;
        beep_ticks_q  = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed: everything enabled, short beeps ---
        set_idling(0);
        apply_settings(5'b11111, 3840, 6400, 10880, 25000, 2, 2, 1000);
        tick_pending.push_back(make_tick(0, 0, 0, 0, 0, 0));              // bare tick
        tick_pending.push_back(make_tick(1, 3840, 1000, 0, 0, 0));        // at ramp start
        tick_pending.push_back(make_tick(1, 3841, 1000, 0, 1, 0));        // just inside
        tick_pending.push_back(make_tick(1, 5120, 1000, 0, 100, 0));      // mid ramp
        tick_pending.push_back(make_tick(1, 6399, 1000, 0, 65535, 0));    // rpm saturates
        tick_pending.push_back(make_tick(1, 6400, 0, 0, 16'h5555, 0));    // at full
        tick_pending.push_back(make_tick(1, -32768, 24999, 0, 16'hAAAA, 0));
        tick_pending.push_back(make_tick(1, 10879, 0, 0, 0, 0));          // below temp trip
        tick_pending.push_back(make_tick(1, 10880, 0, 0, 0, 0));          // temp trip, beeps
        repeat (6)
            tick_pending.push_back(make_tick(0, 0, 0, 0, 0, 0));          // run sequencer
        tick_pending.push_back(make_tick(1, 0, 0, 1, 0, 0));              // alert, latched
        tick_pending.push_back(make_tick(0, 0, 0, 0, 0, 1));              // clear only
        tick_pending.push_back(make_tick(1, 0, 25000, 0, 0, 0));          // power trip
        tick_pending.push_back(make_tick(1, 0, 0, 1, 0, 1));              // clear then alert
        tick_pending.push_back(make_tick(1, 32767, 24'hFFFFFF, 1, 65535, 1));
        tick_pending.push_back(make_tick(1, 100, 0, 0, 0, 1));            // clear, calm
        tick_pending.push_back(make_tick(0, 32767, 24'hFFFFFF, 1, 0, 0)); // no sample
        drain();

        // --- random phases, idling mode rotates every phase ---
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_idling(p % 4);
            case (p)
                // widest ramp, trips at the top, zero-length beeps, max count
                0: apply_settings(5'b11111, -32768, 32767, 32767, 24'hFFFFFF, 0, 255, 1);
                // empty ramp, both limits off (alert ignored), no buzzer
                1: apply_settings(5'b11111, 1000, 1000, 0, 0, 65535, 0, 65535);
                // everything off: sequencer frozen, fan zero, rpm held
                2: apply_settings(5'b00000, 3840, 6400, 10880, 25000, 500, 3, 1000);
                // reversed ramp, minimal trips, one beep
                3: apply_settings(5'b11111, 5000, -5000, 1, 1, 1, 1, 7);
                default: apply_random_settings();
            endcase
            repeat (HALF_PHASE)
                tick_pending.push_back(random_tick());
            // sender stops until every status word is back
            drain();
            repeat (HALF_PHASE)
                tick_pending.push_back(random_tick());
            drain();
        end

        repeat (END_WAIT) @(posedge aclk);
        if (status_due.size() != 0) begin
            $error("%0d status transfers never arrived", status_due.size());
            fails++;
        end
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tpp_pkg.sv
rtl/tpp_div.sv
rtl/thermal_power_protection_unit.sv
tb/sv/thermal_power_protection_unit_tb.sv
